// ===== rtl/core/hsfc_pkg.sv =====
// Package for the sensor reply checker and converter.
// Holds the job type passed between the front and back parts, the CRC-8
// step function and the scaling constants. No dependencies.
package hsfc_pkg;

  // Job handed from the frame checker to the converter, one per frame.
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] raw;
    logic        kind;
  } job_t;

  localparam int HSFC_QUEUE_DEPTH = 2;

  localparam logic [7:0]  CRC_POLY_LOW = 8'h31;   // 0x131 with bit 8 dropped
  localparam logic [15:0] STATUS_MASK  = 16'hFFFC;

  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  localparam int SPAN_W   = 15;
  localparam int PROD_W   = 16 + SPAN_W;
  localparam int SCALED_W = 15;

  localparam logic [SPAN_W-1:0] TEMP_SPAN = 15'd17572;
  localparam logic [SPAN_W-1:0] HUM_SPAN  = 15'd12500;

  localparam logic signed [SCALED_W:0] TEMP_OFFSET = -16'sd4685;
  localparam logic signed [SCALED_W:0] HUM_OFFSET  = -16'sd600;

  // One byte through the MSB-first CRC-8, no reflection.
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY_LOW;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/hsfc_front.sv =====
// Front part: tracks the byte position within a reply, runs the CRC over
// the two data bytes and emits one job on the crc byte. Uses hsfc_pkg.
module hsfc_front
  import hsfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,          // byte transaction this cycle
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  logic       measure_kind,
  output logic       push,
  output job_t       job
);

  localparam logic [1:0] POS_MSB = 2'd0;
  localparam logic [1:0] POS_LSB = 2'd1;
  localparam logic [1:0] POS_CRC = 2'd2;

  logic [1:0] pos_r,  pos_nxt;
  logic [7:0] crc_r,  crc_nxt;
  logic [7:0] high_r, high_nxt;
  logic [7:0] low_r,  low_nxt;
  logic       kind_r, kind_nxt;
  logic       new_frame;

  // A start mark always opens a new frame; so does any byte at position
  // zero (or the unused code three).
  assign new_frame = frame_start || (pos_r != POS_LSB && pos_r != POS_CRC);

  assign push       = acc && !new_frame && (pos_r == POS_CRC);
  assign job.crc_ok = (crc_r == data_byte);
  assign job.raw    = {high_r, low_r} & STATUS_MASK;
  assign job.kind   = kind_r;

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    kind_nxt = kind_r;
    if (acc) begin
      if (new_frame) begin
        kind_nxt = measure_kind;
        high_nxt = data_byte;
        crc_nxt  = crc8_feed(8'h00, data_byte);
        pos_nxt  = POS_LSB;
      end else begin
        unique case (pos_r)
          POS_LSB: begin
            low_nxt = data_byte;
            crc_nxt = crc8_feed(crc_r, data_byte);
            pos_nxt = POS_CRC;
          end
          POS_CRC: begin
            crc_nxt = 8'h00;
            pos_nxt = POS_MSB;
          end
          default: begin
            pos_nxt = POS_MSB;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_MSB;
      crc_r  <= 8'h00;
      high_r <= 8'h00;
      low_r  <= 8'h00;
      kind_r <= KIND_TEMP;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      kind_r <= kind_nxt;
    end
  end

endmodule

// ===== rtl/core/hsfc_queue.sv =====
// Short job queue between the frame checker and the converter.
// Register-based ring with a fill count. Uses hsfc_pkg.
module hsfc_queue
  import hsfc_pkg::*;
#(
  parameter int DEPTH = HSFC_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r,    cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/hsfc_back.sv =====
// Back part: scales the masked reading. Stage one multiplies by the span,
// stage two adds the offset into the output register. Uses hsfc_pkg.
module hsfc_back
  import hsfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  job_t                job,
  output logic                job_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output logic                res_crc_ok,
  output logic [15:0]         res_raw,
  output logic [SCALED_W-1:0] res_scaled,
  output logic                res_kind
);

  logic                s1_v_r;
  logic                s1_ok_r;
  logic [15:0]         s1_raw_r;
  logic                s1_kind_r;
  logic [SCALED_W-1:0] s1_prod_r;   // product >> 16, always non-negative
  logic                out_v_r;
  logic                out_ok_r;
  logic [15:0]         out_raw_r;
  logic [SCALED_W-1:0] out_scaled_r;
  logic                out_kind_r;

  logic                   load_out;
  logic [SPAN_W-1:0]      span;
  logic [PROD_W-1:0]      prod;
  logic signed [SCALED_W:0] offset;
  logic signed [SCALED_W:0] sum;

  assign load_out  = !out_v_r || res_ready;
  assign job_ready = !s1_v_r || load_out;

  assign span   = (job.kind == KIND_HUM) ? HUM_SPAN : TEMP_SPAN;
  assign prod   = PROD_W'(job.raw) * PROD_W'(span);
  assign offset = (s1_kind_r == KIND_HUM) ? HUM_OFFSET : TEMP_OFFSET;
  assign sum    = offset + $signed({1'b0, s1_prod_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (job_ready) begin
        s1_v_r <= job_valid;
      end
      if (load_out) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) begin
      s1_ok_r   <= job.crc_ok;
      s1_raw_r  <= job.raw;
      s1_kind_r <= job.kind;
      s1_prod_r <= prod[PROD_W-1:16];
    end
    if (load_out) begin
      out_ok_r     <= s1_ok_r;
      out_kind_r   <= s1_kind_r;
      out_raw_r    <= s1_ok_r ? s1_raw_r : 16'h0000;
      out_scaled_r <= s1_ok_r ? sum[SCALED_W-1:0] : '0;
    end
  end

  assign res_valid  = out_v_r;
  assign res_crc_ok = out_ok_r;
  assign res_raw    = out_raw_r;
  assign res_scaled = out_scaled_r;
  assign res_kind   = out_kind_r;

endmodule

// ===== rtl/core/humidity_sensor_frame_check_convert.sv =====
// Top level of the sensor reply checker and converter.
// Instantiates hsfc_front, hsfc_queue and hsfc_back; uses hsfc_pkg.
//
// Usage:
//   The in_ channel carries the sensor reply one byte per transaction:
//   msb, lsb, then crc. in_tuser[0] marks the first byte of a reply and
//   in_tuser[1] gives its kind (0 temperature, 1 humidity), sampled on the
//   first byte only. A start mark in mid-reply drops the partial frame.
//   The out_ channel gives one transaction per complete reply: the masked
//   reading, the scaled value in hundredths (deg C or %RH) and the CRC
//   verdict. On a CRC mismatch reading and scaled value are zero.
//   After the transaction of the crc byte, the job passes the job queue,
//   the multiply stage and the output register before the result is valid.
//   Throughput: one byte per cycle while in_tready is high. in_tready
//   only drops when the job queue is full, which happens once the receiver
//   has stalled long enough to back up the multiply and output stages and
//   QUEUE_DEPTH queued jobs. Stalls of the receiver leave the output held.
//   Reset (synchronous, rst_n low) empties the queue and pipeline and
//   returns the frame tracker to the first byte with a zero CRC.
module humidity_sensor_frame_check_convert
  import hsfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = HSFC_QUEUE_DEPTH   // at least 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic [1:0]  in_tuser,    // [0] frame_start, [1] measure_kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] raw_reading, [30:16] scaled_value, [31] zero
  output logic [1:0]  out_tuser    // [0] crc_ok, [1] result_kind
);

  logic                in_acc;
  logic                q_push;
  logic                q_ready;
  job_t                q_in_job;
  logic                q_valid;
  job_t                q_out_job;
  logic                back_ready;
  logic                res_crc_ok;
  logic [15:0]         res_raw;
  logic [SCALED_W-1:0] res_scaled;
  logic                res_kind;

  // The front only needs room in the queue on a crc byte, but holding off
  // every byte while the queue is full keeps the ready path registered.
  assign in_tready = q_ready;
  assign in_acc    = in_tvalid && in_tready;

  hsfc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .data_byte    (in_tdata),
    .frame_start  (in_tuser[0]),
    .measure_kind (in_tuser[1]),
    .push         (q_push),
    .job          (q_in_job)
  );

  hsfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in_job),
    .push_ready (q_ready),
    .pop        (back_ready),
    .pop_valid  (q_valid),
    .pop_job    (q_out_job)
  );

  hsfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_valid),
    .job        (q_out_job),
    .job_ready  (back_ready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_crc_ok (res_crc_ok),
    .res_raw    (res_raw),
    .res_scaled (res_scaled),
    .res_kind   (res_kind)
  );

  assign out_tdata = {1'b0, res_scaled, res_raw};
  assign out_tuser = {res_kind, res_crc_ok};

  // A failed CRC must never leak a reading.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'h0)
    else $error("reading shown on crc mismatch");

  // The status bits never reach the output.
  a_status_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] == 2'b00)
    else $error("status bits not cleared");

  // The first byte of a reply can never complete a frame.
  a_start_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser[0] |-> !q_push)
    else $error("job pushed on a start byte");

  // A job is never offered to a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_ready)
    else $error("job pushed into full queue");

endmodule
